// File: design/u8t_pkg.sv
package u8t_pkg;

    // frame geometry
    localparam int DATA_BITS = 8;
    localparam int BYTE_W    = 8;
    localparam int PERIOD_W  = 16;
    localparam int RX_TMR_W  = PERIOD_W + 1;

    // bit period after reset (1 MHz tick, 9600 baud)
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000000 / 9600);

    // transmitter status for one tick
    typedef struct packed {
        logic line;
        logic busy;
    } t_tx_res;

    // receiver status for one tick
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              busy;
    } t_rx_res;

endpackage

// File: design/uart_8n1_transceiver_core.sv
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_stall       i_rx_line, i_tx_start, i_tx_byte
// out       output     o_out_valid / i_out_stall     o_tx_line, o_tx_busy, o_rx_valid,
//                                                    o_rx_byte, o_rx_busy
// cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_bit_period
//
// one beat per cycle sustained while the out channel does not stall; each tick beat goes
// input register -> tx/rx update -> result register
// synchronous active-low reset clears both state machines and the beat valids,
// and loads a bit period of 104 ticks
// a stall on the out channel holds the result register and backs up into the
// input register; tick state steps only when a beat moves into the result register
module uart_8n1_transceiver_core #(
    parameter int DATA_BITS = u8t_pkg::DATA_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick beats in
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_rx_line,
    input  logic                           i_tx_start,
    input  logic [u8t_pkg::BYTE_W-1:0]     i_tx_byte,
    // result beats out
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_tx_line,
    output logic                           o_tx_busy,
    output logic                           o_rx_valid,
    output logic [u8t_pkg::BYTE_W-1:0]     o_rx_byte,
    output logic                           o_rx_busy,
    // bit period register
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [u8t_pkg::PERIOD_W-1:0]   i_cfg_bit_period
);

    logic [u8t_pkg::PERIOD_W-1:0] r_bit_period;
    logic [u8t_pkg::PERIOD_W-1:0] w_period;

    logic                         r_in_valid;
    logic                         r_rx_line;
    logic                         r_tx_start;
    logic [u8t_pkg::BYTE_W-1:0]   r_tx_byte;

    logic                         r_out_valid;
    u8t_pkg::t_tx_res             r_tx_res;
    u8t_pkg::t_rx_res             r_rx_res;

    logic                         w_advance;
    logic                         w_in_ready;
    logic                         w_step;
    u8t_pkg::t_tx_res             w_tx_res;
    u8t_pkg::t_rx_res             w_rx_res;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= u8t_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_bit_period <= i_cfg_bit_period;
        end
    end

    // a period of zero counts as one
    assign w_period = (r_bit_period == '0) ? u8t_pkg::PERIOD_W'(1) : r_bit_period;

    // pipeline flow control
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_in_ready = !r_in_valid || w_advance;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_stall = !w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_rx_line  <= i_rx_line;
            r_tx_start <= i_tx_start;
            r_tx_byte  <= i_tx_byte;
        end
    end

    // transmitter and receiver tick logic
    u8t_tx #(
        .DATA_BITS (DATA_BITS)
    ) u_tx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_period (w_period),
        .i_start  (r_tx_start),
        .i_byte   (r_tx_byte),
        .o_res    (w_tx_res)
    );

    u8t_rx #(
        .DATA_BITS (DATA_BITS)
    ) u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_period (w_period),
        .i_line   (r_rx_line),
        .o_res    (w_rx_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_tx_res <= w_tx_res;
            r_rx_res <= w_rx_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_line   = r_tx_res.line;
    assign o_tx_busy   = r_tx_res.busy;
    assign o_rx_valid  = r_rx_res.valid;
    assign o_rx_byte   = r_rx_res.data;
    assign o_rx_busy   = r_rx_res.busy;

`ifndef NO_ASSERTIONS
    // a held input beat is kept until it moves on
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_in_stall |=> r_in_valid)
        else $error("input beat dropped while stalled");

    // idle transmitter keeps the line high
    a_tx_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_busy |-> o_tx_line)
        else $error("tx line low while idle");

    // a completed byte is followed by hold-off
    a_rx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rx_valid |-> o_rx_busy)
        else $error("rx not busy on byte completion");

    // byte field is zero when no byte completes
    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rx_valid |-> (o_rx_byte == '0))
        else $error("rx byte nonzero without valid");
`endif

endmodule

// File: design/u8t_tx.sv
module u8t_tx #(
    parameter int DATA_BITS = u8t_pkg::DATA_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [u8t_pkg::PERIOD_W-1:0]   i_period,
    input  logic                           i_start,
    input  logic [u8t_pkg::BYTE_W-1:0]     i_byte,
    output u8t_pkg::t_tx_res               o_res
);

    localparam int CNT_W = $clog2(DATA_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_BITS - 1);

    typedef enum logic [3:0] {
        TX_IDLE  = 4'b0001,
        TX_START = 4'b0010,
        TX_DATA  = 4'b0100,
        TX_STOP  = 4'b1000
    } t_tx_state;

    t_tx_state                    r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [u8t_pkg::BYTE_W-1:0]   r_shift, n_shift;
    logic [u8t_pkg::PERIOD_W-1:0] r_timer, n_timer;

    // advance the running frame, then take a new request if idle
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_timer = r_timer;
        if (r_state != TX_IDLE) begin
            n_timer = r_timer + 1'b1;
            if (n_timer >= i_period) begin
                n_timer = '0;
                case (r_state)
                    TX_START: begin
                        n_state = TX_DATA;
                        n_cnt   = '0;
                    end
                    TX_DATA: begin
                        n_shift = r_shift >> 1;
                        if (r_cnt == CNT_LAST) begin
                            n_state = TX_STOP;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    default: n_state = TX_IDLE;
                endcase
            end
        end
        if (n_state == TX_IDLE && i_start) begin
            n_state = TX_START;
            n_timer = '0;
            n_shift = i_byte;
        end
    end

    // line level and busy from the updated state
    always_comb begin
        case (n_state)
            TX_START: o_res.line = 1'b0;
            TX_DATA:  o_res.line = n_shift[0];
            default:  o_res.line = 1'b1;
        endcase
        o_res.busy = (n_state != TX_IDLE);
    end

    // state registers, stepped once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TX_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_timer <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_timer <= n_timer;
        end
    end

endmodule

// File: design/u8t_rx.sv
module u8t_rx #(
    parameter int DATA_BITS = u8t_pkg::DATA_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [u8t_pkg::PERIOD_W-1:0]   i_period,
    input  logic                           i_line,
    output u8t_pkg::t_rx_res               o_res
);

    localparam int CNT_W = $clog2(DATA_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_BITS - 1);

    typedef enum logic [2:0] {
        RX_HUNT = 3'b001,
        RX_DATA = 3'b010,
        RX_HOLD = 3'b100
    } t_rx_state;

    t_rx_state                    r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [u8t_pkg::BYTE_W-1:0]   r_shift, n_shift;
    logic [u8t_pkg::RX_TMR_W-1:0] r_timer, n_timer;
    logic [u8t_pkg::RX_TMR_W-1:0] w_target;
    logic                         w_valid;

    // first sample sits 1.5 periods after the start edge
    always_comb begin
        if (r_state == RX_DATA && r_cnt == '0) begin
            w_target = {1'b0, i_period} + {2'b00, i_period[u8t_pkg::PERIOD_W-1:1]};
        end else begin
            w_target = {1'b0, i_period};
        end
    end

    // sample, hold off, then hunt for a low level
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_timer = r_timer;
        w_valid = 1'b0;
        if (r_state != RX_HUNT) begin
            n_timer = r_timer + 1'b1;
            if (n_timer >= w_target) begin
                n_timer = '0;
                case (r_state)
                    RX_DATA: begin
                        for (int i = 0; i < u8t_pkg::BYTE_W; i++) begin
                            if (32'(r_cnt) == i) begin
                                n_shift[i] = r_shift[i] | i_line;
                            end
                        end
                        if (r_cnt == CNT_LAST) begin
                            w_valid = 1'b1;
                            n_state = RX_HOLD;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    default: n_state = RX_HUNT;
                endcase
            end
        end
        if (n_state == RX_HUNT && !i_line) begin
            n_state = RX_DATA;
            n_cnt   = '0;
            n_timer = '0;
            n_shift = '0;
        end
    end

    // byte shows only on the tick of the last sample
    always_comb begin
        o_res.valid = w_valid;
        o_res.data  = w_valid ? n_shift : '0;
        o_res.busy  = (n_state != RX_HUNT);
    end

    // state registers, stepped once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_HUNT;
            r_cnt   <= '0;
            r_shift <= '0;
            r_timer <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_timer <= n_timer;
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    // predictor phases
    localparam bit [3:0] TX_IDLE  = 4'd0;
    localparam bit [3:0] TX_START = 4'd1;
    localparam bit [3:0] TX_STOP  = 4'(u8t_pkg::DATA_BITS + 2);
    localparam bit [3:0] RX_HUNT  = 4'd0;
    localparam bit [3:0] RX_FIRST = 4'd1;
    localparam bit [3:0] RX_HOLD  = 4'(u8t_pkg::DATA_BITS + 1);

    // run control
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 8;
    localparam int HOLD_CYCLES = 64;
    localparam int PRINT_LIMIT = 50;

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    // one result beat: transmitter and receiver status
    typedef struct packed {
        u8t_pkg::t_tx_res tx;
        u8t_pkg::t_rx_res rx;
    } t_tick_status;

    // tracks the serial state per tick and holds the status beats still due
    class uart_status_board;
        bit [u8t_pkg::PERIOD_W-1:0] bit_period;
        bit [3:0]                   tx_phase;
        bit [u8t_pkg::BYTE_W-1:0]   tx_shift;
        bit [u8t_pkg::PERIOD_W-1:0] tx_timer;
        bit [3:0]                   rx_phase;
        bit [u8t_pkg::BYTE_W-1:0]   rx_shift;
        bit [u8t_pkg::RX_TMR_W-1:0] rx_timer;
        t_tick_status               expected_status[$];
        int                         errors;
        int                         results_seen;

        function new();
            bit_period   = u8t_pkg::PERIOD_RESET;
            tx_phase     = TX_IDLE;
            tx_shift     = '0;
            tx_timer     = '0;
            rx_phase     = RX_HUNT;
            rx_shift     = '0;
            rx_timer     = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_period(bit [u8t_pkg::PERIOD_W-1:0] value);
            bit_period = value;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // advance both state machines by one tick and queue the status it gives
        function void note_tick(bit line, bit start, bit [u8t_pkg::BYTE_W-1:0] data);
            int unsigned  ticks;
            int unsigned  target;
            int           idx;
            t_tick_status want;
            want  = '0;
            ticks = (bit_period == 0) ? 1 : bit_period;

            // transmitter: timer first, then a request if idle
            if (tx_phase != TX_IDLE) begin
                tx_timer = tx_timer + 1'b1;
                if (tx_timer >= ticks) begin
                    tx_timer = '0;
                    if (tx_phase >= 2 && tx_phase < TX_STOP)
                        tx_shift = tx_shift >> 1;
                    tx_phase = (tx_phase >= TX_STOP) ? 4'(TX_IDLE) : tx_phase + 1'b1;
                end
            end
            if (tx_phase == TX_IDLE && start) begin
                tx_phase = TX_START;
                tx_timer = '0;
                tx_shift = data;
            end
            if (tx_phase == TX_IDLE || tx_phase >= TX_STOP)
                want.tx.line = 1'b1;
            else if (tx_phase == TX_START)
                want.tx.line = 1'b0;
            else
                want.tx.line = tx_shift[0];
            want.tx.busy = (tx_phase != TX_IDLE);

            // receiver: first sample after one and a half periods
            if (rx_phase != RX_HUNT) begin
                target   = (rx_phase == 1) ? (ticks * 3) / 2 : ticks;
                rx_timer = rx_timer + 1'b1;
                if (rx_timer >= target) begin
                    rx_timer = '0;
                    if (rx_phase == RX_HOLD) begin
                        rx_phase = RX_HUNT;
                    end else begin
                        idx = rx_phase - 1;
                        if (idx < u8t_pkg::BYTE_W)
                            rx_shift[idx] = rx_shift[idx] | line;
                        if (rx_phase == u8t_pkg::DATA_BITS) begin
                            want.rx.valid = 1'b1;
                            want.rx.data  = rx_shift;
                        end
                        rx_phase = rx_phase + 1'b1;
                    end
                end
            end
            if (rx_phase == RX_HUNT && !line) begin
                rx_phase = RX_FIRST;
                rx_timer = '0;
                rx_shift = '0;
            end
            want.rx.busy = (rx_phase != RX_HUNT);
            expected_status.push_back(want);
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("ERROR result %0d: %s", results_seen, what);
        endtask

        // compare one accepted result beat against the oldest expected status
        task check_status(t_tick_status got);
            t_tick_status want;
            results_seen++;
            if (expected_status.size() == 0) begin
                report("result beat with no tick outstanding");
                return;
            end
            want = expected_status.pop_front();
            if (got.tx.line !== want.tx.line)
                report($sformatf("tx_line %b, want %b", got.tx.line, want.tx.line));
            if (got.tx.busy !== want.tx.busy)
                report($sformatf("tx_busy %b, want %b", got.tx.busy, want.tx.busy));
            if (got.rx.valid !== want.rx.valid)
                report($sformatf("rx_valid %b, want %b", got.rx.valid, want.rx.valid));
            if (got.rx.data !== want.rx.data)
                report($sformatf("rx_byte %h, want %h", got.rx.data, want.rx.data));
            if (got.rx.busy !== want.rx.busy)
                report($sformatf("rx_busy %b, want %b", got.rx.busy, want.rx.busy));
        endtask
    endclass

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_in_valid       = 1'b0;
    logic                         o_in_stall;
    logic                         i_rx_line        = 1'b1;
    logic                         i_tx_start       = 1'b0;
    logic [u8t_pkg::BYTE_W-1:0]   i_tx_byte        = '0;
    logic                         o_out_valid;
    logic                         i_out_stall      = 1'b0;
    logic                         o_tx_line;
    logic                         o_tx_busy;
    logic                         o_rx_valid;
    logic [u8t_pkg::BYTE_W-1:0]   o_rx_byte;
    logic                         o_rx_busy;
    logic                         i_cfg_valid      = 1'b0;
    logic                         o_cfg_ready;
    logic [u8t_pkg::PERIOD_W-1:0] i_cfg_bit_period = '0;

    uart_status_board sb = new();
    t_idle_mode       idle_mode   = IDLE_RX_HEAVY;
    bit               hold_req    = 1'b0;
    int               quiet_cycles = 0;
    bit               line_bits[$];

    uart_8n1_transceiver_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_line        (i_rx_line),
        .i_tx_start       (i_tx_start),
        .i_tx_byte        (i_tx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tx_line        (o_tx_line),
        .o_tx_busy        (o_tx_busy),
        .o_rx_valid       (o_rx_valid),
        .o_rx_byte        (o_rx_byte),
        .o_rx_busy        (o_rx_busy),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_bit_period (i_cfg_bit_period)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 37;
            IDLE_TX_HEAVY: return 73;
            default:       return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 73;
            IDLE_TX_HEAVY: return 37;
            default:       return 0;
        endcase
    endfunction

    // result side stall, with a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = roll(recv_idle_pct());
            end
        end
    end

    // result beat monitor
    always @(posedge i_clk) begin
        t_tick_status got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.tx.line  = o_tx_line;
            got.tx.busy  = o_tx_busy;
            got.rx.valid = o_rx_valid;
            got.rx.data  = o_rx_byte;
            got.rx.busy  = o_rx_busy;
            sb.check_status(got);
        end
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // offer one tick beat, with random idle cycles ahead of it
    task automatic send_tick(bit line, bit start, bit [u8t_pkg::BYTE_W-1:0] data);
        @(negedge i_clk);
        while (roll(send_idle_pct())) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_line  = line;
        i_tx_start = start;
        i_tx_byte  = data;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_tick(line, start, data);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_results();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // period change only with the pipeline empty
    task automatic write_period(bit [u8t_pkg::PERIOD_W-1:0] value);
        stop_sending();
        wait_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_bit_period = value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_period(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receive line: mostly whole frames, some cut short, some noise
    function automatic void queue_line(int unsigned per);
        int unsigned              kind;
        int unsigned              cut;
        bit [u8t_pkg::BYTE_W-1:0] data;
        bit                       frame[$];
        kind = $urandom_range(0, 9);
        data = u8t_pkg::BYTE_W'($urandom());
        repeat ($urandom_range(0, per)) line_bits.push_back(1'b1);
        if (kind == 9) begin
            repeat ($urandom_range(1, 3 * per))
                line_bits.push_back(1'($urandom_range(0, 1)));
            return;
        end
        repeat (per) frame.push_back(1'b0);
        for (int i = 0; i < u8t_pkg::BYTE_W; i++)
            repeat (per) frame.push_back(data[i]);
        repeat (per) frame.push_back(1'b1);
        cut = (kind >= 7) ? $urandom_range(1, frame.size() - 1) : frame.size();
        for (int i = 0; i < cut; i++)
            line_bits.push_back(frame[i]);
    endfunction

    task automatic play_ticks(int count, int unsigned per, int hold_at, int pause_at);
        int unsigned line_per;
        line_per = (per > 8) ? 8 : per;
        line_bits.delete();
        for (int k = 0; k < count; k++) begin
            if (k == hold_at)
                hold_req = 1'b1;
            if (k == pause_at) begin
                stop_sending();
                wait_results();
            end
            if (line_bits.size() == 0)
                queue_line(line_per);
            send_tick(line_bits.pop_front(), roll(25), u8t_pkg::BYTE_W'($urandom()));
        end
    endtask

    // stimulus
    initial begin
        bit [11:0]   line_pat;
        int unsigned mid_period;
        line_pat = 12'b0110_1001_0011;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset period: frame start, request while busy, receiver catches a start bit
        send_tick(1'b1, 1'b1, 8'hA5);
        send_tick(1'b1, 1'b1, 8'h5A);
        send_tick(1'b0, 1'b0, 8'h00);
        send_tick(1'b0, 1'b0, 8'hFF);

        // shortest period mid-bit; start held high for back-to-back frames
        write_period(16'd1);
        for (int k = 0; k < 12; k++)
            send_tick(line_pat[k], 1'b1, (k < 6) ? 8'hFF : 8'h00);

        // zero period runs as one
        write_period(16'd0);
        for (int k = 0; k < 6; k++)
            send_tick(k[0], k < 3, 8'h81);

        // random frames, lowest legal period
        write_period(16'd2);
        play_ticks(220, 2, -1, -1);

        idle_mode  = IDLE_TX_HEAVY;
        mid_period = $urandom_range(3, 6);
        write_period(u8t_pkg::PERIOD_W'(mid_period));
        play_ticks(200, mid_period, -1, -1);

        // no idling; back up the pipe, then let it drain fully
        idle_mode = IDLE_NONE;
        write_period(16'd5);
        play_ticks(180, 5, 50, 120);

        // largest period: timers only
        write_period(16'hFFFF);
        play_ticks(50, 16'hFFFF, -1, -1);

        stop_sending();
        wait_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
design/u8t_pkg.sv
design/u8t_tx.sv
design/u8t_rx.sv
design/uart_8n1_transceiver_core.sv
dv/tb.sv
